// ----- hdl/wfc_pkg.sv -----
// Shared codes and character classes of the word frequency counter.
package wfc_pkg;

	localparam logic [1:0] KIND_TEXT = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic RK_WORD = 1'b0;
	localparam logic RK_CHAR = 1'b1;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
			(c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
	endfunction

endpackage

// ----- hdl/wfc_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module wfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/word_frequency_counter_unit.sv -----
// Word frequency counter: word collection, sequential table search, insert and readout.
//
//  channel  | handshake            | fields
//  ---------+----------------------+---------------------------------------------
//  in       | start & !busy        | kind, text_byte, entry_index
//  out      | strobe (one cycle)   | result_kind, slot, word_count, is_new, dropped,
//           |                      | truncated, char_out, char_valid, last,
//           |                      | entries_in_use
//
// A text byte in a word is taken while idle. A word end runs S_FIN, then per searched
// entry S_LEN, S_LCHK and per compared character S_CREQ, S_CCHK, then S_HIT for a hit,
// S_MISS for a drop, or S_MISS, S_CPR/S_CPW per character and S_NEW for an insert. A
// readout runs S_RD1, S_RD2, then S_RC, S_RCO per character. Reset clears all control
// state; the table needs no clearing. Results cannot be stalled.
module word_frequency_counter_unit
	import wfc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 1024,
	parameter int WORD_BYTES    = 64,
	parameter int COUNT_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  text_byte,
	input  logic [9:0]  entry_index,
	output logic        strobe,
	output logic        result_kind,
	output logic [9:0]  slot,
	output logic [31:0] word_count,
	output logic        is_new,
	output logic        dropped,
	output logic        truncated,
	output logic [7:0]  char_out,
	output logic        char_valid,
	output logic        last,
	output logic [10:0] entries_in_use
);

	localparam int EW         = $clog2(TABLE_ENTRIES);
	localparam int IW         = $clog2(WORD_BYTES);
	localparam int PW         = $clog2(WORD_BYTES + 1);
	localparam int UW         = $clog2(TABLE_ENTRIES + 1);
	localparam int KEEP       = WORD_BYTES - 1;
	localparam int CHAR_DEPTH = TABLE_ENTRIES * (1 << IW);
	localparam int CW         = $clog2(CHAR_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_FIN, S_LEN, S_LCHK, S_CREQ, S_CCHK, S_HIT, S_MISS,
		S_CPR, S_CPW, S_NEW, S_RD1, S_RD2, S_RC, S_RCO
	} state_t;

	state_t                state_q;
	logic [PW-1:0]         plen_q;
	logic                  in_word_q;
	logic                  ovf_q;
	logic                  punct_q;
	logic [UW-1:0]         used_q;
	logic [EW-1:0]         e_q;
	logic [IW-1:0]         i_q;
	logic [IW-1:0]         keep_q;
	logic                  trunc_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [IW-1:0]         rlen_q;

	logic                  strobe_q;
	logic                  rkind_q;
	logic [9:0]            slot_q;
	logic [31:0]           wcount_q;
	logic                  is_new_q;
	logic                  dropped_q;
	logic                  trunc_out_q;
	logic [7:0]            char_q;
	logic                  cvalid_q;
	logic                  last_q;
	logic [10:0]           inuse_q;

	logic [7:0]            ch_lc;
	logic [PW-1:0]         base_len;
	logic                  accept;
	logic                  pend_we;
	logic [7:0]            pend_rdata;
	logic                  char_we;
	logic [7:0]            char_rdata;
	logic                  len_we;
	logic [IW-1:0]         len_rdata;
	logic                  cnt_we;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [COUNT_BITS-1:0] cnt_rdata;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [PW-1:0]         fin_len;
	logic                  fin_trunc;
	logic [IW-1:0]         fin_keep;
	logic                  last_entry;
	logic                  last_char;
	logic                  last_rchar;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign ch_lc    = (text_byte >= CH_UPPER_A && text_byte <= CH_UPPER_Z) ?
		text_byte + CASE_DELTA : text_byte;
	assign base_len = in_word_q ? plen_q : '0;
	assign pend_we  = accept && (kind == KIND_TEXT) && !is_space(text_byte) &&
		(32'(base_len) < KEEP);

	// drop one trailing punctuation character unless the word overflowed
	assign fin_len   = plen_q - PW'((punct_q && !ovf_q && plen_q != '0) ? 1 : 0);
	assign fin_trunc = 32'(fin_len) > KEEP;
	assign fin_keep  = fin_trunc ? IW'(KEEP) : IW'(fin_len);

	assign last_entry = (32'(e_q) + 1) >= 32'(used_q);
	assign last_char  = (32'(i_q) + 1) == 32'(keep_q);
	assign last_rchar = (32'(i_q) + 1) == 32'(rlen_q);
	assign cnt_inc    = (cnt_q == {COUNT_BITS{1'b1}}) ? cnt_q : cnt_q + 1'b1;

	assign char_we   = (state_q == S_CPW);
	assign len_we    = (state_q == S_NEW);
	assign cnt_we    = (state_q == S_NEW) || (state_q == S_HIT);
	assign cnt_wdata = (state_q == S_NEW) ? COUNT_BITS'(1) : cnt_inc;

	wfc_ram #(.WIDTH(8), .DEPTH(WORD_BYTES)) u_pend_ram (
		.clk   (clk),
		.we    (pend_we),
		.waddr (IW'(base_len)),
		.wdata (ch_lc),
		.raddr (i_q),
		.rdata (pend_rdata)
	);

	wfc_ram #(.WIDTH(8), .DEPTH(CHAR_DEPTH)) u_char_ram (
		.clk   (clk),
		.we    (char_we),
		.waddr (CW'({e_q, i_q})),
		.wdata (pend_rdata),
		.raddr (CW'({e_q, i_q})),
		.rdata (char_rdata)
	);

	wfc_ram #(.WIDTH(IW), .DEPTH(TABLE_ENTRIES)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (e_q),
		.wdata (keep_q),
		.raddr (e_q),
		.rdata (len_rdata)
	);

	wfc_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (e_q),
		.wdata (cnt_wdata),
		.raddr (e_q),
		.rdata (cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			plen_q    <= '0;
			in_word_q <= 1'b0;
			ovf_q     <= 1'b0;
			punct_q   <= 1'b0;
			used_q    <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (kind)
							KIND_TEXT: begin
								if (is_space(text_byte)) begin
									if (in_word_q) begin
										state_q <= S_FIN;
									end
								end else begin
									in_word_q <= 1'b1;
									if (32'(base_len) < WORD_BYTES) begin
										plen_q <= base_len + 1'b1;
										ovf_q  <= in_word_q ? ovf_q : 1'b0;
									end else begin
										plen_q <= base_len;
										ovf_q  <= 1'b1;
									end
									punct_q <= is_punct(ch_lc);
								end
							end
							KIND_END: begin
								if (in_word_q) begin
									state_q <= S_FIN;
								end
							end
							KIND_READ: begin
								if (32'(entry_index) >= 32'(used_q)) begin
									strobe_q    <= 1'b1;
									rkind_q     <= RK_CHAR;
									slot_q      <= entry_index;
									wcount_q    <= '0;
									is_new_q    <= 1'b0;
									dropped_q   <= 1'b0;
									trunc_out_q <= 1'b0;
									char_q      <= '0;
									cvalid_q    <= 1'b0;
									last_q      <= 1'b1;
									inuse_q     <= 11'(used_q);
								end else begin
									e_q     <= EW'(entry_index);
									state_q <= S_RD1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FIN: begin
					in_word_q <= 1'b0;
					keep_q    <= fin_keep;
					trunc_q   <= fin_trunc;
					e_q       <= '0;
					state_q   <= (used_q == '0) ? S_MISS : S_LEN;
				end
				S_LEN: begin
					state_q <= S_LCHK;
				end
				S_LCHK: begin
					cnt_q <= cnt_rdata;
					i_q   <= '0;
					if (len_rdata == keep_q) begin
						state_q <= (keep_q == '0) ? S_HIT : S_CREQ;
					end else if (last_entry) begin
						state_q <= S_MISS;
					end else begin
						e_q     <= e_q + 1'b1;
						state_q <= S_LEN;
					end
				end
				S_CREQ: begin
					state_q <= S_CCHK;
				end
				S_CCHK: begin
					if (char_rdata != pend_rdata) begin
						if (last_entry) begin
							state_q <= S_MISS;
						end else begin
							e_q     <= e_q + 1'b1;
							state_q <= S_LEN;
						end
					end else if (last_char) begin
						state_q <= S_HIT;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_CREQ;
					end
				end
				S_HIT: begin
					strobe_q    <= 1'b1;
					rkind_q     <= RK_WORD;
					slot_q      <= 10'(e_q);
					wcount_q    <= 32'(cnt_inc);
					is_new_q    <= 1'b0;
					dropped_q   <= 1'b0;
					trunc_out_q <= trunc_q;
					char_q      <= '0;
					cvalid_q    <= 1'b0;
					last_q      <= 1'b1;
					inuse_q     <= 11'(used_q);
					state_q     <= S_IDLE;
				end
				S_MISS: begin
					if (32'(used_q) < TABLE_ENTRIES) begin
						e_q     <= EW'(used_q);
						i_q     <= '0;
						state_q <= (keep_q == '0) ? S_NEW : S_CPR;
					end else begin
						strobe_q    <= 1'b1;
						rkind_q     <= RK_WORD;
						slot_q      <= '0;
						wcount_q    <= '0;
						is_new_q    <= 1'b0;
						dropped_q   <= 1'b1;
						trunc_out_q <= trunc_q;
						char_q      <= '0;
						cvalid_q    <= 1'b0;
						last_q      <= 1'b1;
						inuse_q     <= 11'(used_q);
						state_q     <= S_IDLE;
					end
				end
				S_CPR: begin
					state_q <= S_CPW;
				end
				S_CPW: begin
					if (last_char) begin
						state_q <= S_NEW;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_CPR;
					end
				end
				S_NEW: begin
					used_q      <= used_q + 1'b1;
					strobe_q    <= 1'b1;
					rkind_q     <= RK_WORD;
					slot_q      <= 10'(e_q);
					wcount_q    <= 32'd1;
					is_new_q    <= 1'b1;
					dropped_q   <= 1'b0;
					trunc_out_q <= trunc_q;
					char_q      <= '0;
					cvalid_q    <= 1'b0;
					last_q      <= 1'b1;
					inuse_q     <= 11'(used_q + 1'b1);
					state_q     <= S_IDLE;
				end
				S_RD1: begin
					state_q <= S_RD2;
				end
				S_RD2: begin
					cnt_q  <= cnt_rdata;
					rlen_q <= len_rdata;
					i_q    <= '0;
					if (len_rdata == '0) begin
						strobe_q    <= 1'b1;
						rkind_q     <= RK_CHAR;
						slot_q      <= 10'(e_q);
						wcount_q    <= 32'(cnt_rdata);
						is_new_q    <= 1'b0;
						dropped_q   <= 1'b0;
						trunc_out_q <= 1'b0;
						char_q      <= '0;
						cvalid_q    <= 1'b0;
						last_q      <= 1'b1;
						inuse_q     <= 11'(used_q);
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_RC;
					end
				end
				S_RC: begin
					state_q <= S_RCO;
				end
				S_RCO: begin
					strobe_q    <= 1'b1;
					rkind_q     <= RK_CHAR;
					slot_q      <= 10'(e_q);
					wcount_q    <= 32'(cnt_q);
					is_new_q    <= 1'b0;
					dropped_q   <= 1'b0;
					trunc_out_q <= 1'b0;
					char_q      <= char_rdata;
					cvalid_q    <= 1'b1;
					last_q      <= last_rchar;
					inuse_q     <= 11'(used_q);
					if (last_rchar) begin
						state_q <= S_IDLE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_RC;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe         = strobe_q;
	assign result_kind    = rkind_q;
	assign slot           = slot_q;
	assign word_count     = wcount_q;
	assign is_new         = is_new_q;
	assign dropped        = dropped_q;
	assign truncated      = trunc_out_q;
	assign char_out       = char_q;
	assign char_valid     = cvalid_q;
	assign last           = last_q;
	assign entries_in_use = inuse_q;

endmodule
